/* rtl/core/trem_pkg.sv */
// Shared constants, types and the quarter-wave sine table of the phased tremolo.
`timescale 1ns / 1ps

package trem_pkg;

  localparam int MAX_LANES      = 8;
  localparam int CHANNELS       = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;
  localparam int QUARTER        = 1 << QUARTER_BITS;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int STEP_BITS      = 32;
  localparam int DEPTH_BITS     = 16;
  localparam int COUNT_BITS     = 4;

  // Register indexes on the configuration channel
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MOD_DEPTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS   = 2'd2;

  localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = 16'd32768;

  // Register stages of one lane: sine, depth product, gain, sample product, round
  localparam int LANE_STAGES    = 5;
  localparam int STAGE_CNT_BITS = 3;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t                       lane_vec_t [MAX_LANES];
  typedef logic        [15:0]            qmag_t;
  typedef qmag_t                         qtab_t [QUARTER];

  localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // Q1.15 magnitude of sin(k * quarter turn / QUARTER), Taylor series in Q30
  function automatic qmag_t quarter_sine(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (k * HALF_PI_Q30 + 64'(QUARTER / 2)) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k < QUARTER; k++) begin
      t[k] = quarter_sine(64'(k));
    end
    return t;
  endfunction

  localparam qtab_t QTAB  = build_qtab();
  localparam qmag_t QPEAK = quarter_sine(64'(QUARTER));

endpackage

/* rtl/core/trem_in_if.sv */
// Input frame channel: valid/ready handshake and eight input samples.
`timescale 1ns / 1ps

interface trem_in_if;
  import trem_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;
  sample_t sample_4;
  sample_t sample_5;
  sample_t sample_6;
  sample_t sample_7;

  modport source (
    output valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    input  ready
  );

  modport sink (
    input  valid, sample_0, sample_1, sample_2, sample_3,
           sample_4, sample_5, sample_6, sample_7,
    output ready
  );
endinterface

/* rtl/core/trem_out_if.sv */
// Output frame channel: valid/ready handshake and eight modulated samples.
`timescale 1ns / 1ps

interface trem_out_if;
  import trem_pkg::*;

  logic    valid;
  logic    ready;
  sample_t out_0;
  sample_t out_1;
  sample_t out_2;
  sample_t out_3;
  sample_t out_4;
  sample_t out_5;
  sample_t out_6;
  sample_t out_7;

  modport source (
    output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
    input  ready
  );

  modport sink (
    input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
    output ready
  );
endinterface

/* rtl/core/trem_cfg_if.sv */
// Configuration write channel: valid/ready handshake, register index and data.
`timescale 1ns / 1ps

interface trem_cfg_if;
  import trem_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/trem_lane.sv */
// One channel lane: phase offset, sine lookup, gain and rounded, saturated product.
`timescale 1ns / 1ps

module trem_lane #(
  parameter int LANE = 0
) (
  input  logic                                 clk,
  input  trem_pkg::sample_t                    sample,
  input  logic [trem_pkg::PHASE_BITS-1:0]      base_phase,
  input  logic [trem_pkg::DEPTH_BITS-1:0]      depth,
  input  logic [trem_pkg::COUNT_BITS-1:0]      count,
  output trem_pkg::sample_t                    result
);
  import trem_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + 33;
  localparam int Y_BITS    = PROD_BITS - 31;

  // Offset of this lane for each channel count: floor(LANE * turn / n)
  localparam logic [PHASE_BITS-1:0] OFF_DIV1 = PHASE_BITS'((64'(LANE) << PHASE_BITS) / 1);
  localparam logic [PHASE_BITS-1:0] OFF_DIV2 = PHASE_BITS'((64'(LANE) << PHASE_BITS) / 2);
  localparam logic [PHASE_BITS-1:0] OFF_DIV3 = PHASE_BITS'((64'(LANE) << PHASE_BITS) / 3);
  localparam logic [PHASE_BITS-1:0] OFF_DIV4 = PHASE_BITS'((64'(LANE) << PHASE_BITS) / 4);
  localparam logic [PHASE_BITS-1:0] OFF_DIV5 = PHASE_BITS'((64'(LANE) << PHASE_BITS) / 5);
  localparam logic [PHASE_BITS-1:0] OFF_DIV6 = PHASE_BITS'((64'(LANE) << PHASE_BITS) / 6);
  localparam logic [PHASE_BITS-1:0] OFF_DIV7 = PHASE_BITS'((64'(LANE) << PHASE_BITS) / 7);
  localparam logic [PHASE_BITS-1:0] OFF_DIV8 = PHASE_BITS'((64'(LANE) << PHASE_BITS) / 8);

  localparam sample_t SAMPLE_HI = sample_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam sample_t SAMPLE_LO = sample_t'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

  logic [PHASE_BITS-1:0]        offset;
  logic [PHASE_BITS-1:0]        phase;
  logic [SINE_ADDR_BITS-1:0]    addr;
  logic [1:0]                   quad;
  logic [QUARTER_BITS-1:0]      r;
  logic [QUARTER_BITS-1:0]      tab_idx;
  qmag_t                        mag;
  logic signed [15:0]           mag_s;
  logic signed [15:0]           sine_next;
  logic signed [15:0]           sine;
  logic signed [32:0]           sd_next;
  logic signed [32:0]           sd;
  logic [31:0]                  bias_next;
  logic [31:0]                  bias;
  logic signed [32:0]           gain_sum;
  logic [31:0]                  gain_next;
  logic [31:0]                  gain;
  logic signed [PROD_BITS-1:0]  prod_next;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [PROD_BITS-1:0]  rounded;
  logic signed [Y_BITS-1:0]     y;
  sample_t                      result_next;

  always_comb begin
    case (count)
      4'd2:    offset = OFF_DIV2;
      4'd3:    offset = OFF_DIV3;
      4'd4:    offset = OFF_DIV4;
      4'd5:    offset = OFF_DIV5;
      4'd6:    offset = OFF_DIV6;
      4'd7:    offset = OFF_DIV7;
      4'd8:    offset = OFF_DIV8;
      default: offset = OFF_DIV1;
    endcase
  end

  // Stage 1: channel phase and sine from the quarter-wave table
  always_comb begin
    phase   = base_phase + offset;
    addr    = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    quad    = addr[SINE_ADDR_BITS-1 -: 2];
    r       = addr[QUARTER_BITS-1:0];
    tab_idx = quad[0] ? QUARTER_BITS'((QUARTER_BITS+1)'(QUARTER) - (QUARTER_BITS+1)'(r)) : r;
    if (quad[0] && (r == '0)) begin
      mag = QPEAK;
    end else begin
      mag = QTAB[tab_idx];
    end
    mag_s     = $signed({1'b0, mag[14:0]});
    sine_next = quad[1] ? -mag_s : mag_s;
  end

  // Stage 2: sine times depth, and the bias 1 - depth/2 in Q1.31
  always_comb begin
    sd_next   = 33'(sine) * $signed({17'd0, depth});
    bias_next = {17'(17'h10000 - 17'(depth)), 15'd0};
  end

  // Stage 3: gain in Q1.31, never negative and at most one
  always_comb begin
    gain_sum  = sd + $signed({1'b0, bias});
    gain_next = gain_sum[31:0];
  end

  // Stage 4: sample times gain
  always_comb begin
    prod_next = PROD_BITS'(sample) * $signed({{(PROD_BITS-32){1'b0}}, gain});
  end

  // Stage 5: round half up, floor shift and saturate
  always_comb begin
    rounded = prod + (PROD_BITS'(1) <<< 30);
    y       = rounded[PROD_BITS-1:31];
    if (y > Y_BITS'(SAMPLE_HI)) begin
      result_next = SAMPLE_HI;
    end else if (y < Y_BITS'(SAMPLE_LO)) begin
      result_next = SAMPLE_LO;
    end else begin
      result_next = y[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    sine   <= sine_next;
    sd     <= sd_next;
    bias   <= bias_next;
    gain   <= gain_next;
    prod   <= prod_next;
    result <= result_next;
  end

endmodule

/* rtl/core/trem_merge.sv */
// Merge stage: gathers lane results, zeroes unused channels, holds the output frame.
`timescale 1ns / 1ps

module trem_merge #(
  parameter int CHANNELS = trem_pkg::CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  trem_pkg::lane_vec_t             lanes,
  input  logic [trem_pkg::COUNT_BITS-1:0] count,
  input  logic                            load,
  output logic                            can_load,
  trem_out_if.source                      frame_out
);
  import trem_pkg::*;

  sample_t out_frame [MAX_LANES];
  logic    out_valid;

  assign can_load = !out_valid || frame_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (frame_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < MAX_LANES; k++) begin
        if ((k < CHANNELS) && (COUNT_BITS'(k) < count)) begin
          out_frame[k] <= lanes[k];
        end else begin
          out_frame[k] <= '0;
        end
      end
    end
  end

  assign frame_out.valid = out_valid;
  assign frame_out.out_0 = out_frame[0];
  assign frame_out.out_1 = out_frame[1];
  assign frame_out.out_2 = out_frame[2];
  assign frame_out.out_3 = out_frame[3];
  assign frame_out.out_4 = out_frame[4];
  assign frame_out.out_5 = out_frame[5];
  assign frame_out.out_6 = out_frame[6];
  assign frame_out.out_7 = out_frame[7];

endmodule

/* rtl/core/multichannel_phased_tremolo.sv */
// Top level of the multichannel phased tremolo: registers, lanes and merge stage.
`timescale 1ns / 1ps
// Path from input transaction to output valid: input frame register, five lane register
//   stages, then the output register.
// One frame is in the lanes at a time, and input ready returns the cycle after the
//   finished frame moves into the output register.
// The output register holds a finished frame while the next one is worked on.
// Reset (rst, synchronous): phase 0, phase_step 0, mod_depth 0, chan_count CHANNELS,
//   lanes idle, output empty.

module multichannel_phased_tremolo #(
  parameter int CHANNELS = trem_pkg::CHANNELS
) (
  input  logic       clk,
  input  logic       rst,
  trem_in_if.sink    frame_in,
  trem_out_if.source frame_out,
  trem_cfg_if.sink   cfg
);
  import trem_pkg::*;

  // Configuration registers; depth and channel count are stored already clamped
  logic [STEP_BITS-1:0]  phase_step;
  logic [DEPTH_BITS-1:0] mod_depth;
  logic [COUNT_BITS-1:0] chan_count;
  logic [COUNT_BITS-1:0] chan_count_next;
  logic [DEPTH_BITS-1:0] depth_next;

  // Running phase and the phase captured for the frame in flight
  logic [PHASE_BITS-1:0] base_phase;
  logic [PHASE_BITS-1:0] frame_phase;

  // Frame in flight
  sample_t                   samples [MAX_LANES];
  logic                      busy;
  logic [STAGE_CNT_BITS-1:0] stage_cnt;
  logic                      accept;
  logic                      cfg_write;
  logic                      done;
  logic                      load;
  logic                      can_load;
  lane_vec_t                 lane_out;

  assign frame_in.ready = !busy;
  assign cfg.ready      = 1'b1;
  assign accept         = frame_in.valid && !busy;
  assign cfg_write      = cfg.valid;
  assign done           = busy && (stage_cnt == STAGE_CNT_BITS'(LANE_STAGES));
  assign load           = done && can_load;

  // Clamp the written values: depth to full scale, channel count to 1..CHANNELS
  always_comb begin
    if (cfg.data[DEPTH_BITS-1:0] > DEPTH_FULL) begin
      depth_next = DEPTH_FULL;
    end else begin
      depth_next = cfg.data[DEPTH_BITS-1:0];
    end
    if (cfg.data[COUNT_BITS-1:0] == '0) begin
      chan_count_next = COUNT_BITS'(1);
    end else if (cfg.data[COUNT_BITS-1:0] > COUNT_BITS'(CHANNELS)) begin
      chan_count_next = COUNT_BITS'(CHANNELS);
    end else begin
      chan_count_next = cfg.data[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      mod_depth  <= '0;
      chan_count <= COUNT_BITS'(CHANNELS);
    end else if (cfg_write) begin
      case (cfg.index)
        REG_PHASE_STEP: phase_step <= cfg.data[STEP_BITS-1:0];
        REG_MOD_DEPTH:  mod_depth  <= depth_next;
        REG_CHANNELS:   chan_count <= chan_count_next;
        default:        ;
      endcase
    end
  end

  // Advance the phase once per accepted frame; the frame keeps the phase it arrived with
  always_ff @(posedge clk) begin
    if (rst) begin
      base_phase <= '0;
    end else if (accept) begin
      base_phase <= base_phase + PHASE_BITS'(phase_step);
    end
  end

  // Sequence the frame through the lanes; hold the count at the end until the merge loads
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      stage_cnt <= '0;
    end else if (accept) begin
      busy      <= 1'b1;
      stage_cnt <= '0;
    end else if (load) begin
      busy      <= 1'b0;
    end else if (busy && !done) begin
      stage_cnt <= stage_cnt + STAGE_CNT_BITS'(1);
    end
  end

  // Input frame register stays stable while the lanes work on it
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_phase <= base_phase;
      samples[0]  <= frame_in.sample_0;
      samples[1]  <= frame_in.sample_1;
      samples[2]  <= frame_in.sample_2;
      samples[3]  <= frame_in.sample_3;
      samples[4]  <= frame_in.sample_4;
      samples[5]  <= frame_in.sample_5;
      samples[6]  <= frame_in.sample_6;
      samples[7]  <= frame_in.sample_7;
    end
  end

  // One lane per channel; channels beyond CHANNELS have no hardware and read zero
  for (genvar c = 0; c < MAX_LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      trem_lane #(
        .LANE (c)
      ) u_lane (
        .clk        (clk),
        .sample     (samples[c]),
        .base_phase (frame_phase),
        .depth      (mod_depth),
        .count      (chan_count),
        .result     (lane_out[c])
      );
    end else begin : g_off
      assign lane_out[c] = '0;
    end
  end

  trem_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .lanes     (lane_out),
    .count     (chan_count),
    .load      (load),
    .can_load  (can_load),
    .frame_out (frame_out)
  );

  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    accept |=> base_phase == $past(base_phase + PHASE_BITS'(phase_step)))
    else $error("phase did not advance by phase_step after a frame");

  a_load_after_pipe: assert property (@(posedge clk) disable iff (rst)
    load |-> busy && stage_cnt == STAGE_CNT_BITS'(LANE_STAGES))
    else $error("frame merged before the lanes finished");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !frame_in.ready)
    else $error("input taken while a frame is in the lanes");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> frame_out.valid)
    else $error("merged frame not presented");

endmodule
